[rtl/pfr_pkg.sv]
// pfr_pkg: shared constants, register codes and stage payload types of the frame rotator
package pfr_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int COEF_W    = 18;
   localparam int PERIOD_W  = 31;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = DATA_W + COEF_W;
   localparam int CYL_W     = DATA_W + 1;
   localparam int SUM_W     = DATA_W + 3;

   localparam logic signed [COEF_W-1:0]   COS_RESET    = COEF_W'(1 << FRAC_W);
   localparam logic signed [COEF_W-1:0]   SIN_RESET    = '0;
   localparam logic signed [DATA_W-1:0]   OFFSET_RESET = '0;
   localparam logic        [PERIOD_W-1:0] PERIOD_RESET = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE   = 3'd0,
      CSR_COS    = 3'd1,
      CSR_SIN    = 3'd2,
      CSR_OFFSET = 3'd3,
      CSR_PERIOD = 3'd4
   } csr_index_type;

   typedef enum logic {
      MODE_PLANAR      = 1'b0,
      MODE_CYLINDRICAL = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                    mode;
      logic signed [COEF_W-1:0]    cos_angle;
      logic signed [COEF_W-1:0]    sin_angle;
      logic signed [DATA_W-1:0]    shift_offset;
      logic        [PERIOD_W-1:0]  period_length;
   } cfg_type;

   // raw products, c = cosine, s = sine
   typedef struct packed {
      mode_type                    mode;
      logic signed [PROD_W-1:0]    pcx;
      logic signed [PROD_W-1:0]    psy;
      logic signed [PROD_W-1:0]    psx;
      logic signed [PROD_W-1:0]    pcy;
      logic signed [PROD_W-1:0]    vcx;
      logic signed [PROD_W-1:0]    vsy;
      logic signed [PROD_W-1:0]    vsx;
      logic signed [PROD_W-1:0]    vcy;
      logic signed [CYL_W-1:0]     shift_x;
      logic signed [DATA_W-1:0]    pos_y;
   } prod_type;

   typedef struct packed {
      mode_type                    mode;
      logic signed [SUM_W-1:0]     pcx;
      logic signed [SUM_W-1:0]     psy;
      logic signed [SUM_W-1:0]     psx;
      logic signed [SUM_W-1:0]     pcy;
      logic signed [SUM_W-1:0]     vcx;
      logic signed [SUM_W-1:0]     vsy;
      logic signed [SUM_W-1:0]     vsx;
      logic signed [SUM_W-1:0]     vcy;
      logic signed [SUM_W-1:0]     wrap_x;
      logic                        wrap_error;
      logic signed [DATA_W-1:0]    pos_y;
   } rnd_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]     pos_x;
      logic signed [SUM_W-1:0]     pos_y;
      logic signed [SUM_W-1:0]     vel_x;
      logic signed [SUM_W-1:0]     vel_y;
      logic                        wrap_error;
   } sum_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]    new_pos_x;
      logic signed [DATA_W-1:0]    new_pos_y;
      logic signed [DATA_W-1:0]    new_vel_x;
      logic signed [DATA_W-1:0]    new_vel_y;
      logic                        wrap_error;
   } res_type;

endpackage

[rtl/pfr_mult.sv]
// pfr_mult: first stage, eight coefficient products and the shifted position x
module pfr_mult (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [pfr_pkg::DATA_W-1:0]  pos_x,
   input  logic signed [pfr_pkg::DATA_W-1:0]  pos_y,
   input  logic signed [pfr_pkg::DATA_W-1:0]  vel_x,
   input  logic signed [pfr_pkg::DATA_W-1:0]  vel_y,
   input  pfr_pkg::cfg_type                   cfg,
   output logic                               out_valid,
   input  logic                               out_ready,
   output pfr_pkg::prod_type                  out_data
);

   logic              valid_ff, valid_in;
   pfr_pkg::prod_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.mode    = cfg.mode;
      data_in.pcx     = cfg.cos_angle * pos_x;
      data_in.psy     = cfg.sin_angle * pos_y;
      data_in.psx     = cfg.sin_angle * pos_x;
      data_in.pcy     = cfg.cos_angle * pos_y;
      data_in.vcx     = cfg.cos_angle * vel_x;
      data_in.vsy     = cfg.sin_angle * vel_y;
      data_in.vsx     = cfg.sin_angle * vel_x;
      data_in.vcy     = cfg.cos_angle * vel_y;
      data_in.shift_x = pfr_pkg::CYL_W'(pos_x) + pfr_pkg::CYL_W'(cfg.shift_offset);
      data_in.pos_y   = pos_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/pfr_round.sv]
// pfr_round: second stage, round products to nearest and wrap the shifted x once
module pfr_round (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  pfr_pkg::prod_type                    in_data,
   input  logic [pfr_pkg::PERIOD_W-1:0]         period_length,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output pfr_pkg::rnd_type                     out_data
);

   localparam int PW = pfr_pkg::PROD_W;
   localparam int SW = pfr_pkg::SUM_W;
   localparam int FW = pfr_pkg::FRAC_W;
   localparam logic signed [PW-1:0] ROUND_HALF = {{(PW-FW){1'b0}}, 1'b1, {(FW-1){1'b0}}};

   // floor((p + half) / 2^frac), ties go up
   function automatic logic signed [SW-1:0] round_term(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] q;
      begin
         q = p + ROUND_HALF;
         return SW'(q >>> FW);
      end
   endfunction

   logic              valid_ff, valid_in;
   pfr_pkg::rnd_type  data_ff, data_in;

   logic signed [SW-1:0] x, per, per2, add_x, sub_x;
   logic                 neg, ge;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      x     = SW'(in_data.shift_x);
      per   = $signed({{(SW-pfr_pkg::PERIOD_W){1'b0}}, period_length});
      per2  = per <<< 1;
      add_x = x + per;
      sub_x = x - per;
      neg   = x[SW-1];
      ge    = x >= per;

      data_in.mode   = in_data.mode;
      data_in.pcx    = round_term(in_data.pcx);
      data_in.psy    = round_term(in_data.psy);
      data_in.psx    = round_term(in_data.psx);
      data_in.pcy    = round_term(in_data.pcy);
      data_in.vcx    = round_term(in_data.vcx);
      data_in.vsy    = round_term(in_data.vsy);
      data_in.vsx    = round_term(in_data.vsx);
      data_in.vcy    = round_term(in_data.vcy);
      data_in.pos_y  = in_data.pos_y;
      data_in.wrap_x = neg ? add_x : (ge ? sub_x : x);
      // still out of range after one correction
      data_in.wrap_error = (in_data.mode == pfr_pkg::MODE_CYLINDRICAL) &&
                           (neg ? add_x[SW-1] : (x >= per2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/pfr_sum.sv]
// pfr_sum: third stage, rotation sums and mode selection for position
module pfr_sum (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pfr_pkg::rnd_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pfr_pkg::sum_type   out_data
);

   logic              valid_ff, valid_in;
   pfr_pkg::sum_type  data_ff, data_in;
   logic              cyl;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      cyl = (in_data.mode == pfr_pkg::MODE_CYLINDRICAL);
      data_in.pos_x      = cyl ? in_data.wrap_x : (in_data.pcx - in_data.psy);
      data_in.pos_y      = cyl ? pfr_pkg::SUM_W'(in_data.pos_y) : (in_data.psx + in_data.pcy);
      data_in.vel_x      = in_data.vcx - in_data.vsy;
      data_in.vel_y      = in_data.vsx + in_data.vcy;
      data_in.wrap_error = in_data.wrap_error;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/pfr_sat.sv]
// pfr_sat: last stage, saturation to the data range and the result register
module pfr_sat (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pfr_pkg::sum_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pfr_pkg::res_type   out_data
);

   localparam int DW = pfr_pkg::DATA_W;
   localparam int SW = pfr_pkg::SUM_W;
   localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};

   function automatic logic signed [DW-1:0] sat_data(input logic signed [SW-1:0] v);
      logic fits;
      begin
         fits = (v[SW-1:DW-1] == '0) || (v[SW-1:DW-1] == '1);
         if (fits) begin
            return v[DW-1:0];
         end else if (v[SW-1]) begin
            return DATA_MIN;
         end else begin
            return DATA_MAX;
         end
      end
   endfunction

   logic              valid_ff, valid_in;
   pfr_pkg::res_type  data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.new_pos_x  = sat_data(in_data.pos_x);
      data_in.new_pos_y  = sat_data(in_data.pos_y);
      data_in.new_vel_x  = sat_data(in_data.vel_x);
      data_in.new_vel_y  = sat_data(in_data.vel_y);
      data_in.wrap_error = in_data.wrap_error;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/particle_frame_rotator.sv]
// particle_frame_rotator: top level, configuration registers and the four-stage pipeline
//
// rotates one particle (position and velocity, signed Q16.16) per transfer by the
// programmed cosine and sine (signed Q2.16), or in cylindrical mode shifts position x
// by an offset and wraps it into [0, period) with a single add or subtract, passing
// position y through and still rotating velocity. products round to nearest with ties
// upward, sums saturate to 32 bits, and wrap_error flags an x that one correction could
// not bring into range. the pipeline takes a new transfer every cycle unless the result
// is stalled and passes it through multiply, round and wrap, sum and saturate; a stalled
// result backs up stage by stage, so req_ready only drops when all four stages are full.
// configuration writes take effect at once and belong in idle periods only.
module particle_frame_rotator (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pfr_pkg::DATA_W-1:0]   req_pos_x,
   input  logic signed [pfr_pkg::DATA_W-1:0]   req_pos_y,
   input  logic signed [pfr_pkg::DATA_W-1:0]   req_vel_x,
   input  logic signed [pfr_pkg::DATA_W-1:0]   req_vel_y,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pfr_pkg::DATA_W-1:0]   rsp_new_pos_x,
   output logic signed [pfr_pkg::DATA_W-1:0]   rsp_new_pos_y,
   output logic signed [pfr_pkg::DATA_W-1:0]   rsp_new_vel_x,
   output logic signed [pfr_pkg::DATA_W-1:0]   rsp_new_vel_y,
   output logic                                rsp_wrap_error,
   // register write port
   input  logic                                csr_we,
   input  logic [pfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfr_pkg::DATA_W-1:0]          csr_wdata
);

   pfr_pkg::cfg_type  cfg_ff, cfg_in;

   logic              prod_valid, prod_ready;
   pfr_pkg::prod_type prod_data;
   logic              rnd_valid, rnd_ready;
   pfr_pkg::rnd_type  rnd_data;
   logic              sum_valid, sum_ready;
   pfr_pkg::sum_type  sum_data;
   pfr_pkg::res_type  res_data;

   // register writes, value truncated to the register width, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pfr_pkg::CSR_MODE:   cfg_in.mode = pfr_pkg::mode_type'(csr_wdata[0]);
            pfr_pkg::CSR_COS:    cfg_in.cos_angle = csr_wdata[pfr_pkg::COEF_W-1:0];
            pfr_pkg::CSR_SIN:    cfg_in.sin_angle = csr_wdata[pfr_pkg::COEF_W-1:0];
            pfr_pkg::CSR_OFFSET: cfg_in.shift_offset = csr_wdata;
            pfr_pkg::CSR_PERIOD: cfg_in.period_length = csr_wdata[pfr_pkg::PERIOD_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= pfr_pkg::MODE_PLANAR;
         cfg_ff.cos_angle     <= pfr_pkg::COS_RESET;
         cfg_ff.sin_angle     <= pfr_pkg::SIN_RESET;
         cfg_ff.shift_offset  <= pfr_pkg::OFFSET_RESET;
         cfg_ff.period_length <= pfr_pkg::PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage 1: eight 18x32 products plus the offset add
   pfr_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .cfg       (cfg_ff),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // stage 2: rounding and the single wrap correction
   pfr_round u_round (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (prod_valid),
      .in_ready      (prod_ready),
      .in_data       (prod_data),
      .period_length (cfg_ff.period_length),
      .out_valid     (rnd_valid),
      .out_ready     (rnd_ready),
      .out_data      (rnd_data)
   );

   // stage 3: rotation sums
   pfr_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rnd_valid),
      .in_ready  (rnd_ready),
      .in_data   (rnd_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   // stage 4: saturation into the result register
   pfr_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (res_data)
   );

   assign rsp_new_pos_x  = res_data.new_pos_x;
   assign rsp_new_pos_y  = res_data.new_pos_y;
   assign rsp_new_vel_x  = res_data.new_vel_x;
   assign rsp_new_vel_y  = res_data.new_vel_y;
   assign rsp_wrap_error = res_data.wrap_error;

   // back-pressure only reaches the input through a stalled result
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a stalled result");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a result taken with one waiting behind it is replaced in the next cycle
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sum_valid) |=> rsp_valid)
      else $error("pipeline bubble after transfer with a full sum stage");

endmodule
